[hw/rtl/krt_pkg.sv]
`timescale 1ns / 1ps
// Package for the keyed record table: depth, field widths, request and
// status codes, record and result types, and the controller state type.
// No dependencies.
package krt_pkg;

	localparam int DEPTH = 64;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam int REQ_W   = 3;
	localparam int KEY_W   = 16;
	localparam int QTY_W   = 20;
	localparam int PRICE_W = 24;
	localparam int STAT_W  = 2;

	typedef enum logic [REQ_W-1:0] {
		REQ_ADD    = 3'd0,
		REQ_DELETE = 3'd1,
		REQ_SEARCH = 3'd2,
		REQ_UPDATE = 3'd3,
		REQ_DUMP   = 3'd4
	} req_type_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_EMPTY    = 2'd2,
		STAT_NOTFOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [QTY_W-1:0]   quantity;
		logic [PRICE_W-1:0] price_cents;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	typedef struct packed {
		status_t status;
		rec_t    rec;
		logic    last;
	} rsp_t;

	typedef enum logic [2:0] {
		SM_IDLE,
		SM_SCAN,
		SM_SHIFT,
		SM_RESP,
		SM_DUMP_RD,
		SM_DUMP_WR
	} state_t;

endpackage

[hw/rtl/krt_req_if.sv]
`timescale 1ns / 1ps
// Request channel of the keyed record table: valid, ready and the request fields.
// Depends on krt_pkg for the field widths.
interface krt_req_if;
	logic                          valid;
	logic                          ready;
	logic [krt_pkg::REQ_W-1:0]     req_type;
	logic [krt_pkg::KEY_W-1:0]     key;
	logic [krt_pkg::KEY_W-1:0]     new_key;
	logic [krt_pkg::QTY_W-1:0]     quantity;
	logic [krt_pkg::PRICE_W-1:0]   price_cents;

	modport source (output valid, req_type, key, new_key, quantity, price_cents,
		input ready);
	modport sink (input valid, req_type, key, new_key, quantity, price_cents,
		output ready);
endinterface

[hw/rtl/krt_rsp_if.sv]
`timescale 1ns / 1ps
// Result channel of the keyed record table: valid, ready and the result fields.
// Depends on krt_pkg for the field widths.
interface krt_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [krt_pkg::STAT_W-1:0]    status;
	logic [krt_pkg::KEY_W-1:0]     out_key;
	logic [krt_pkg::QTY_W-1:0]     out_quantity;
	logic [krt_pkg::PRICE_W-1:0]   out_price_cents;
	logic                          last;

	modport source (output valid, status, out_key, out_quantity, out_price_cents, last,
		input ready);
	modport sink (input valid, status, out_key, out_quantity, out_price_cents, last,
		output ready);
endinterface

[hw/rtl/krt_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module krt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

[hw/rtl/keyed_record_table_top.sv]
`timescale 1ns / 1ps
// Keyed record table: a fixed-depth table of key, quantity and price records.
// Depends on krt_pkg, krt_req_if, krt_rsp_if and krt_ram.
//
// Requests arrive on the req channel and results leave on the rsp channel;
// each transaction completes when valid and ready are both high. One request
// is worked on at a time, and req.ready is high only while the controller is
// idle. Records sit in one RAM with a registered read port; a scan reads one
// entry per cycle. Add writes its record from the idle state and answers from
// the result state. Search and update scan from the newest entry. Delete scans
// from the oldest entry and then moves every later record down one slot. Dump
// gives one result per record, newest first, with last set on the oldest
// record. Requests with an unknown code are taken and dropped.
// Results go through an output register, so a new request is taken while the
// previous result waits; when the receiver stalls, a finished request waits
// for that register to free up. Reset empties the table at once; the RAM
// contents are not cleared.
module keyed_record_table_top (
	input  logic      clk,
	input  logic      arst_n,
	krt_req_if.sink   req,
	krt_rsp_if.source rsp
);
	import krt_pkg::*;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [IDX_W-1:0]  ptr_q, ptr_d;
	logic              issue_q, issue_d;
	req_type_t         op_q, op_d;
	logic [KEY_W-1:0]  key_q, key_d;
	rec_t              nrec_q, nrec_d;
	rsp_t              res_q, res_d;
	rsp_t              out_q, out_d;
	logic              out_vld_q;
	logic              out_load;
	logic              out_free;
	logic              rd_vld_s1;
	logic [IDX_W-1:0]  rd_idx_s1;
	logic              rd_en;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	rec_t              mem_wdata;
	logic [REC_W-1:0]  mem_rdata;
	rec_t              rd_rec;
	logic [CNT_W-1:0]  cnt_m1;
	logic              up;
	logic              ptr_end;
	logic              s1_end;
	logic              s1_last_up;
	logic              s1_hit;

	krt_ram #(.WIDTH(REC_W), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (ptr_q),
		.rdata (mem_rdata)
	);

	assign rd_rec     = rec_t'(mem_rdata);
	assign cnt_m1     = cnt_q - CNT_W'(1);
	assign up         = (op_q == REQ_DELETE);
	assign ptr_end    = up ? (ptr_q == cnt_m1[IDX_W-1:0]) : (ptr_q == '0);
	assign s1_last_up = (rd_idx_s1 == cnt_m1[IDX_W-1:0]);
	assign s1_end     = up ? s1_last_up : (rd_idx_s1 == '0);
	assign s1_hit     = (rd_rec.key == key_q);
	assign out_free   = !out_vld_q || rsp.ready;

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		ptr_d     = ptr_q;
		issue_d   = issue_q;
		op_d      = op_q;
		key_d     = key_q;
		nrec_d    = nrec_q;
		res_d     = res_q;
		out_d     = res_q;
		out_load  = 1'b0;
		rd_en     = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = ptr_q;
		mem_wdata = nrec_q;
		case (state_q)
			SM_IDLE: begin
				if (req.valid) begin
					key_d  = req.key;
					nrec_d = '{key: req.new_key, quantity: req.quantity,
						price_cents: req.price_cents};
					op_d   = req_type_t'(req.req_type);
					case (req.req_type)
						REQ_ADD: begin
							res_d = '{status: STAT_OK, rec: '0, last: 1'b1};
							if (cnt_q == CNT_W'(DEPTH)) begin
								res_d.status = STAT_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = cnt_q[IDX_W-1:0];
								mem_wdata = '{key: req.key, quantity: req.quantity,
									price_cents: req.price_cents};
								cnt_d     = cnt_q + CNT_W'(1);
							end
							state_d = SM_RESP;
						end
						REQ_DELETE, REQ_SEARCH, REQ_UPDATE, REQ_DUMP: begin
							if (cnt_q == '0) begin
								res_d   = '{status: STAT_EMPTY, rec: '0, last: 1'b1};
								state_d = SM_RESP;
							end else if (req.req_type == REQ_DELETE) begin
								ptr_d   = '0;
								issue_d = 1'b1;
								state_d = SM_SCAN;
							end else if (req.req_type == REQ_DUMP) begin
								ptr_d   = cnt_m1[IDX_W-1:0];
								state_d = SM_DUMP_RD;
							end else begin
								ptr_d   = cnt_m1[IDX_W-1:0];
								issue_d = 1'b1;
								state_d = SM_SCAN;
							end
						end
						default: begin
						end
					endcase
				end
			end
			SM_SCAN: begin
				rd_en = issue_q;
				if (issue_q) begin
					if (ptr_end) begin
						issue_d = 1'b0;
					end else begin
						ptr_d = up ? ptr_q + IDX_W'(1) : ptr_q - IDX_W'(1);
					end
				end
				if (rd_vld_s1) begin
					if (s1_hit) begin
						rd_en   = 1'b0;
						issue_d = 1'b0;
						res_d   = '{status: STAT_OK, rec: rd_rec, last: 1'b1};
						state_d = SM_RESP;
						if (op_q == REQ_UPDATE) begin
							mem_we    = 1'b1;
							mem_waddr = rd_idx_s1;
							res_d.rec = nrec_q;
						end else if (op_q == REQ_DELETE) begin
							if (s1_last_up) begin
								cnt_d = cnt_m1;
							end else begin
								ptr_d   = rd_idx_s1 + IDX_W'(1);
								issue_d = 1'b1;
								state_d = SM_SHIFT;
							end
						end
					end else if (s1_end) begin
						rd_en   = 1'b0;
						issue_d = 1'b0;
						res_d   = '{status: STAT_NOTFOUND, rec: '0, last: 1'b1};
						state_d = SM_RESP;
					end
				end
			end
			SM_SHIFT: begin
				rd_en = issue_q;
				if (issue_q) begin
					if (ptr_end) begin
						issue_d = 1'b0;
					end else begin
						ptr_d = ptr_q + IDX_W'(1);
					end
				end
				if (rd_vld_s1) begin
					mem_we    = 1'b1;
					mem_waddr = rd_idx_s1 - IDX_W'(1);
					mem_wdata = rd_rec;
					if (s1_last_up) begin
						cnt_d   = cnt_m1;
						state_d = SM_RESP;
					end
				end
			end
			SM_RESP: begin
				if (out_free) begin
					out_load = 1'b1;
					out_d    = res_q;
					state_d  = SM_IDLE;
				end
			end
			SM_DUMP_RD: begin
				if (out_free) begin
					rd_en   = 1'b1;
					state_d = SM_DUMP_WR;
				end
			end
			SM_DUMP_WR: begin
				out_load = 1'b1;
				out_d    = '{status: STAT_OK, rec: rd_rec, last: (rd_idx_s1 == '0)};
				if (rd_idx_s1 == '0) begin
					state_d = SM_IDLE;
				end else begin
					ptr_d   = ptr_q - IDX_W'(1);
					state_d = SM_DUMP_RD;
				end
			end
			default: begin
				state_d = SM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= SM_IDLE;
			cnt_q     <= '0;
			issue_q   <= 1'b0;
			rd_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			issue_q   <= issue_d;
			rd_vld_s1 <= rd_en;
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ptr_q     <= ptr_d;
		op_q      <= op_d;
		key_q     <= key_d;
		nrec_q    <= nrec_d;
		res_q     <= res_d;
		rd_idx_s1 <= ptr_q;
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign req.ready           = (state_q == SM_IDLE);
	assign rsp.valid           = out_vld_q;
	assign rsp.status          = out_q.status;
	assign rsp.out_key         = out_q.rec.key;
	assign rsp.out_quantity    = out_q.rec.quantity;
	assign rsp.out_price_cents = out_q.rec.price_cents;
	assign rsp.last            = out_q.last;
endmodule
